// File: rtl/mrg_pkg.sv
// mrg_pkg: constants, types and modular helpers for the mrg32k3a generator
// used by mrg_front, mrg_back and mrg32k3a_random_generator_top; no dependencies
package mrg_pkg;

    localparam logic [32:0] MOD_FIRST   = 33'd4294967087;
    localparam logic [32:0] MOD_SECOND  = 33'd4294944443;
    localparam logic [14:0] FOLD_FIRST  = 15'd209;
    localparam logic [14:0] FOLD_SECOND = 15'd22853;
    localparam logic [20:0] MUL_A12     = 21'd1403580;
    localparam logic [20:0] MUL_A13N    = 21'd810728;
    localparam logic [20:0] MUL_A21     = 21'd527612;
    localparam logic [20:0] MUL_A23N    = 21'd1370589;
    localparam logic [31:0] SEED_RESET  = 32'd12345;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] IDX_SEED_A0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_SEED_A1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_SEED_A2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_SEED_B0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_SEED_B1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_SEED_B2 = 3'd5;

    typedef enum logic {
        OP_RAW   = 1'b0,
        OP_SCALE = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [30:0] bound;
    } req_t;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } cfg_wr_t;

    // first fold of a 53-bit product: hi * (2^32 - m) + lo
    function automatic logic [36:0] fold_hi(input logic [52:0] p, input logic [14:0] c);
        fold_hi = {5'd0, p[31:0]} + 37'(p[52:32]) * 37'(c);
    endfunction

    // second fold and final correction into 0..m-1
    function automatic logic [31:0] fold_lo(input logic [36:0] f, input logic [14:0] c,
                                            input logic [32:0] m);
        logic [32:0] s;
        s = {1'b0, f[31:0]} + 33'(f[36:32]) * 33'(c);
        if (s >= m) begin
            s = s - m;
        end
        return s[31:0];
    endfunction

    // (a - b) mod m for a, b already below m
    function automatic logic [31:0] sub_mod(input logic [31:0] a, input logic [31:0] b,
                                            input logic [32:0] m);
        logic [32:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            d = d + m;
        end
        return d[31:0];
    endfunction

endpackage

// File: rtl/mrg_front.sv
// mrg_front: request intake, classification and two-entry queue to the back end
// depends on mrg_pkg
module mrg_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_mode,
    input  logic [30:0]   s_bound,
    output logic          q_valid,
    output mrg_pkg::req_t q_req,
    input  logic          q_pop
);

    mrg_pkg::req_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push;
    logic          pop;
    mrg_pkg::req_t req_in;

    always_comb begin
        req_in.op    = s_mode ? mrg_pkg::OP_SCALE : mrg_pkg::OP_RAW;
        req_in.bound = s_bound;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_req   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= req_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/mrg_back.sv
// mrg_back: recurrence state, modular reduction sequencer, scaling and result register
// depends on mrg_pkg
module mrg_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  mrg_pkg::cfg_wr_t cfg_wr,
    input  logic            q_valid,
    input  mrg_pkg::req_t   q_req,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [31:0]     m_value
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FOLD  = 9'b000000010,
        ST_RED   = 9'b000000100,
        ST_STEP  = 9'b000001000,
        ST_COMB  = 9'b000010000,
        ST_SCALE = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_DIV2  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t      state_reg;
    state_t      state_next;

    logic [31:0] hist_a_reg [3];
    logic [31:0] hist_b_reg [3];

    mrg_pkg::op_t op_reg;
    logic [30:0] bound_reg;
    logic [52:0] pa1_reg;
    logic [52:0] pa0_reg;
    logic [52:0] pb2_reg;
    logic [52:0] pb0_reg;
    logic [36:0] fa1_reg;
    logic [36:0] fa0_reg;
    logic [36:0] fb2_reg;
    logic [36:0] fb0_reg;
    logic [31:0] ra1_reg;
    logic [31:0] ra0_reg;
    logic [31:0] rb2_reg;
    logic [31:0] rb0_reg;
    logic [31:0] x_reg;
    logic [31:0] y_reg;
    logic [31:0] res_reg;
    logic [62:0] prod_reg;
    logic [30:0] quo_reg;
    logic [39:0] rem_reg;
    logic        m_valid_reg;
    logic [31:0] m_value_reg;

    logic        out_free;
    logic        load_out;
    logic [31:0] x_new;
    logic [31:0] y_new;
    logic [32:0] r2;
    logic [31:0] quot;

    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_OUT) && out_free;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;

    assign x_new = mrg_pkg::sub_mod(ra1_reg, ra0_reg, mrg_pkg::MOD_FIRST);
    assign y_new = mrg_pkg::sub_mod(rb2_reg, rb0_reg, mrg_pkg::MOD_SECOND);

    always_comb begin
        r2   = 33'(rem_reg[39:32]) * 33'(mrg_pkg::FOLD_FIRST) + {1'b0, rem_reg[31:0]};
        quot = 32'(quo_reg) + 32'(rem_reg[39:32]) + 32'(r2 >= mrg_pkg::MOD_FIRST);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:  state_next = ST_RED;
            ST_RED:   state_next = ST_STEP;
            ST_STEP:  state_next = ST_COMB;
            ST_COMB:  state_next = (op_reg == mrg_pkg::OP_SCALE) ? ST_SCALE : ST_OUT;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   state_next = ST_DIV2;
            ST_DIV2:  state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // history words: reset, seed loads and recurrence shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                hist_a_reg[i] <= mrg_pkg::SEED_RESET;
                hist_b_reg[i] <= mrg_pkg::SEED_RESET;
            end
        end else if (cfg_wr.valid) begin
            unique case (cfg_wr.index)
                mrg_pkg::IDX_SEED_A0: hist_a_reg[0] <= cfg_wr.data;
                mrg_pkg::IDX_SEED_A1: hist_a_reg[1] <= cfg_wr.data;
                mrg_pkg::IDX_SEED_A2: hist_a_reg[2] <= cfg_wr.data;
                mrg_pkg::IDX_SEED_B0: hist_b_reg[0] <= cfg_wr.data;
                mrg_pkg::IDX_SEED_B1: hist_b_reg[1] <= cfg_wr.data;
                mrg_pkg::IDX_SEED_B2: hist_b_reg[2] <= cfg_wr.data;
                default: ;
            endcase
        end else if (state_reg == ST_STEP) begin
            hist_a_reg[0] <= hist_a_reg[1];
            hist_a_reg[1] <= hist_a_reg[2];
            hist_a_reg[2] <= x_new;
            hist_b_reg[0] <= hist_b_reg[1];
            hist_b_reg[1] <= hist_b_reg[2];
            hist_b_reg[2] <= y_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            op_reg    <= q_req.op;
            bound_reg <= q_req.bound;
            pa1_reg   <= 53'(mrg_pkg::MUL_A12) * 53'(hist_a_reg[1]);
            pa0_reg   <= 53'(mrg_pkg::MUL_A13N) * 53'(hist_a_reg[0]);
            pb2_reg   <= 53'(mrg_pkg::MUL_A21) * 53'(hist_b_reg[2]);
            pb0_reg   <= 53'(mrg_pkg::MUL_A23N) * 53'(hist_b_reg[0]);
        end
        if (state_reg == ST_FOLD) begin
            fa1_reg <= mrg_pkg::fold_hi(pa1_reg, mrg_pkg::FOLD_FIRST);
            fa0_reg <= mrg_pkg::fold_hi(pa0_reg, mrg_pkg::FOLD_FIRST);
            fb2_reg <= mrg_pkg::fold_hi(pb2_reg, mrg_pkg::FOLD_SECOND);
            fb0_reg <= mrg_pkg::fold_hi(pb0_reg, mrg_pkg::FOLD_SECOND);
        end
        if (state_reg == ST_RED) begin
            ra1_reg <= mrg_pkg::fold_lo(fa1_reg, mrg_pkg::FOLD_FIRST, mrg_pkg::MOD_FIRST);
            ra0_reg <= mrg_pkg::fold_lo(fa0_reg, mrg_pkg::FOLD_FIRST, mrg_pkg::MOD_FIRST);
            rb2_reg <= mrg_pkg::fold_lo(fb2_reg, mrg_pkg::FOLD_SECOND, mrg_pkg::MOD_SECOND);
            rb0_reg <= mrg_pkg::fold_lo(fb0_reg, mrg_pkg::FOLD_SECOND, mrg_pkg::MOD_SECOND);
        end
        if (state_reg == ST_STEP) begin
            x_reg <= x_new;
            y_reg <= y_new;
        end
        if (state_reg == ST_COMB) begin
            res_reg <= mrg_pkg::sub_mod(x_reg, y_reg, mrg_pkg::MOD_FIRST);
        end
        if (state_reg == ST_SCALE) begin
            prod_reg <= 63'(res_reg) * 63'(bound_reg);
        end
        // n = hi*m1 + hi*209 + lo
        if (state_reg == ST_DIV) begin
            quo_reg <= prod_reg[62:32];
            rem_reg <= 40'(prod_reg[62:32]) * 40'(mrg_pkg::FOLD_FIRST) + 40'(prod_reg[31:0]);
        end
        if (state_reg == ST_DIV2) begin
            res_reg <= quot;
        end
        if (load_out) begin
            m_value_reg <= res_reg;
        end
    end

endmodule

// File: rtl/mrg32k3a_random_generator_top.sv
// mrg32k3a_random_generator_top: combined multiple recursive generator, top level
// depends on mrg_pkg, mrg_front and mrg_back
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      s_mode[0:0], s_bound[30:0]
//   m_        out        m_valid / m_ready      m_value[31:0]
//   cfg_      in         cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[31:0]
//
// a request passes FOLD, RED, STEP, COMB and, in scaled mode, SCALE, DIV and DIV2
// before OUT, in the reduction sequencer in mrg_back that runs one request at a time
// a two-entry queue takes new requests while a result waits on m_ready
// reset loads all history words with 12345; no clearing pass
// cfg_ready is always high; seed writes load the history word at once
module mrg32k3a_random_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [30:0] s_bound,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [mrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    logic             q_valid;
    logic             q_pop;
    mrg_pkg::req_t    q_req;
    mrg_pkg::cfg_wr_t cfg_wr;
    logic [2:0]       pend_reg;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    mrg_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .s_bound (s_bound),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop)
    );

    mrg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value)
    );

    // requests in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 3'd0;
        end else begin
            pend_reg <= pend_reg + 3'(s_valid && s_ready) - 3'(m_valid && m_ready);
        end
    end

    a_pend_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 3'd4)
        else $error("more requests in flight than storage");

    a_out_has_req: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 3'd0)
        else $error("result without a pending request");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> pend_reg >= 3'd2)
        else $error("intake stalled with queue not full");

    a_pop_once: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> !q_pop)
        else $error("back end took two requests in a row");

endmodule
